@@ hdl/nlf_pkg.sv @@
// ----------------------------------------------------------------------------
// nlf_pkg
// Shared types and constants for the NMEA line framer: function and action
// codes, the command word passed from the FIFO front end to the framer.
// ----------------------------------------------------------------------------
package nlf_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_PULL  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ACT_QUEUED   = 4'd0,
    ACT_FULL     = 4'd1,
    ACT_EMPTY    = 4'd2,
    ACT_IGNORED  = 4'd3,
    ACT_START    = 4'd4,
    ACT_STORED   = 4'd5,
    ACT_DONE     = 4'd6,
    ACT_TOO_LONG = 4'd7,
    ACT_CLEARED  = 4'd8
  } action_e;

  // What the front end decided for one word.
  typedef enum logic [2:0] {
    CMD_QUEUED  = 3'd0,
    CMD_FULL    = 3'd1,
    CMD_EMPTY   = 3'd2,
    CMD_IGNORED = 3'd3,
    CMD_BYTE    = 3'd4,
    CMD_CLEARED = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;   // byte pulled from the FIFO
    logic [7:0]  level;  // FIFO fill level after this word
  } cmd_t;

  localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] LINE_SIZE_RST = 8'd128;
  localparam logic [7:0] LINE_SIZE_MIN = 8'd2;

endpackage

@@ hdl/nlf_front.sv @@
// ----------------------------------------------------------------------------
// nlf_front
// Receive ring FIFO: handles push, pull and clear for each accepted word and
// classifies it into a command word for the framer.
// ----------------------------------------------------------------------------
module nlf_front #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [1:0]    func_i,
  input  logic [7:0]    rx_byte_i,
  output nlf_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [PtrW:0]   DepthExt = (PtrW + 1)'(FIFO_DEPTH);

  logic [7:0] mem [FIFO_DEPTH];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_next, rd_next;
  logic [7:0]      head_q;  // always mirrors mem[rd_ptr_q]
  logic            we;
  logic [PtrW:0]   diff;
  logic [PtrW-1:0] level;

  assign wr_next = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
  assign rd_next = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    we         = 1'b0;
    cmd_o.kind = nlf_pkg::CMD_IGNORED;
    cmd_o.data = head_q;
    case (nlf_pkg::func_e'(func_i))
      nlf_pkg::FUNC_PUSH: begin
        if (wr_next != rd_ptr_q) begin
          we         = accept_i;
          wr_ptr_d   = accept_i ? wr_next : wr_ptr_q;
          cmd_o.kind = nlf_pkg::CMD_QUEUED;
        end else begin
          cmd_o.kind = nlf_pkg::CMD_FULL;
        end
      end
      nlf_pkg::FUNC_PULL: begin
        if (rd_ptr_q == wr_ptr_q) begin
          cmd_o.kind = nlf_pkg::CMD_EMPTY;
        end else begin
          rd_ptr_d   = accept_i ? rd_next : rd_ptr_q;
          cmd_o.kind = nlf_pkg::CMD_BYTE;
        end
      end
      nlf_pkg::FUNC_CLEAR: begin
        if (accept_i) begin
          wr_ptr_d = '0;
          rd_ptr_d = '0;
        end
        cmd_o.kind = nlf_pkg::CMD_CLEARED;
      end
      default: begin
        cmd_o.kind = nlf_pkg::CMD_IGNORED;
      end
    endcase

    // Fill level after the step; the ring may be any depth, not only 2^n.
    diff = {1'b0, wr_ptr_d} - {1'b0, rd_ptr_d};
    if (wr_ptr_d < rd_ptr_d) begin
      diff = diff + DepthExt;
    end
    level       = diff[PtrW-1:0];
    cmd_o.level = 8'(level);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_ptr_q] <= rx_byte_i;
    end
  end

  // Registered read of the next head, with a bypass for a byte being written
  // into the slot the read pointer is about to look at.
  always_ff @(posedge clk_i) begin
    if (we && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= rx_byte_i;
    end else begin
      head_q <= mem[rd_ptr_d];
    end
  end

endmodule

@@ hdl/nlf_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// nlf_cmd_queue
// Two-entry command queue between the FIFO front end and the framer.
// ----------------------------------------------------------------------------
module nlf_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nlf_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output nlf_pkg::cmd_t head_cmd_o
);

  nlf_pkg::cmd_t entry_q [2];
  logic          wr_idx_q, rd_idx_q;
  logic [1:0]    count_q;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_cmd_o   = entry_q[rd_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= 1'b0;
      rd_idx_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_idx_q <= ~wr_idx_q;
      end
      if (pop_i) begin
        rd_idx_q <= ~rd_idx_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_idx_q] <= push_cmd_i;
    end
  end

endmodule

@@ hdl/nlf_back.sv @@
// ----------------------------------------------------------------------------
// nlf_back
// Sentence framer and drop counter, with the registered result stage.
// ----------------------------------------------------------------------------
module nlf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    line_size_i,
  input  logic          head_valid_i,
  input  nlf_pkg::cmd_t head_cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [3:0]    action_o,
  output logic          line_write_o,
  output logic [7:0]    line_pos_out_o,
  output logic [7:0]    line_char_o,
  output logic [7:0]    line_length_o,
  output logic [31:0]   drop_total_o,
  output logic [7:0]    fifo_level_o
);

  logic [7:0]       line_pos_q, line_pos_d;
  logic [31:0]      drop_q, drop_d;
  logic             out_valid_q;
  logic [7:0]       limit;
  logic [7:0]       pos_inc;
  logic [7:0]       b;
  nlf_pkg::action_e act;
  logic             wr;
  logic [7:0]       wpos, wchar, len;

  assign pop_o   = head_valid_i && (!out_valid_q || !out_stall_i);
  assign limit   = ((line_size_i < nlf_pkg::LINE_SIZE_MIN) ? nlf_pkg::LINE_SIZE_MIN
                                                           : line_size_i) - 8'd1;
  assign pos_inc = line_pos_q + 8'd1;
  assign b       = head_cmd_i.data;

  always_comb begin
    line_pos_d = line_pos_q;
    drop_d     = drop_q;
    act        = nlf_pkg::ACT_IGNORED;
    wr         = 1'b0;
    wpos       = 8'd0;
    wchar      = 8'd0;
    len        = 8'd0;
    case (head_cmd_i.kind)
      nlf_pkg::CMD_QUEUED:  act = nlf_pkg::ACT_QUEUED;
      nlf_pkg::CMD_EMPTY:   act = nlf_pkg::ACT_EMPTY;
      nlf_pkg::CMD_FULL: begin
        act    = nlf_pkg::ACT_FULL;
        drop_d = drop_q + 32'd1;
      end
      nlf_pkg::CMD_CLEARED: begin
        act    = nlf_pkg::ACT_CLEARED;
        drop_d = '0;
      end
      nlf_pkg::CMD_BYTE: begin
        if (b == nlf_pkg::CHAR_DOLLAR) begin
          act        = nlf_pkg::ACT_START;
          wr         = 1'b1;
          wchar      = b;
          line_pos_d = 8'd1;
        end else if (line_pos_q == 8'd0) begin
          act = nlf_pkg::ACT_IGNORED;
        end else if (line_pos_q >= limit) begin
          act        = nlf_pkg::ACT_TOO_LONG;
          line_pos_d = 8'd0;
          drop_d     = drop_q + 32'd1;
        end else begin
          wr    = 1'b1;
          wpos  = line_pos_q;
          wchar = b;
          if ((b == nlf_pkg::CHAR_LF) || (b == nlf_pkg::CHAR_CR)) begin
            act        = nlf_pkg::ACT_DONE;
            len        = pos_inc;
            line_pos_d = 8'd0;
          end else begin
            act        = nlf_pkg::ACT_STORED;
            line_pos_d = pos_inc;
          end
        end
      end
      default: act = nlf_pkg::ACT_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pos_q  <= 8'd0;
      drop_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        line_pos_q <= line_pos_d;
        drop_q     <= drop_d;
      end
      out_valid_q <= pop_o || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      action_o       <= act;
      line_write_o   <= wr;
      line_pos_out_o <= wpos;
      line_char_o    <= wchar;
      line_length_o  <= len;
      drop_total_o   <= drop_d;
      fifo_level_o   <= head_cmd_i.level;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/nmea_line_framer_with_fifo_core.sv @@
// ----------------------------------------------------------------------------
// nmea_line_framer_with_fifo_core
// Receive byte FIFO in front of an NMEA sentence framer.
// ----------------------------------------------------------------------------
// Usage: each input word carries a function (push a received byte, pull and
// frame one byte, clear the FIFO and drop counter) and is accepted on a rising
// edge with in_valid_i high and in_stall_o low. Every accepted word yields
// exactly one output word, presented with out_valid_o and taken on an edge
// where out_stall_i is low. Output words tell the action taken, the character
// and position to write into the outside line store, the completed line
// length, the running drop total and the FIFO fill level.
// The front end does the FIFO work in the cycle a word is accepted; the
// framer pops the word from a two-entry queue and registers the result on
// the edge of that pop. The block takes one word per clock while the
// receiver does not stall. When the receiver stalls, the result register
// holds, the queue fills, and in_stall_o rises once two words are waiting.
// The line_size register is written over its own valid/ready channel, which
// is always ready; write it only while the block is idle. Reset empties the
// FIFO, zeroes the counter, closes any open sentence and sets line_size to
// 128. FIFO storage itself is not cleared.
// ----------------------------------------------------------------------------
module nmea_line_framer_with_fifo_core #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  action_o,
  output logic        line_write_o,
  output logic [7:0]  line_pos_out_o,
  output logic [7:0]  line_char_o,
  output logic [7:0]  line_length_o,
  output logic [31:0] drop_total_o,
  output logic [7:0]  fifo_level_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic          accept;
  logic          q_full;
  logic          q_pop;
  logic          q_head_valid;
  nlf_pkg::cmd_t front_cmd;
  nlf_pkg::cmd_t head_cmd;
  logic [7:0]    line_size_q;

  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;
  assign cfg_ready_o = 1'b1;

  // The line size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_size_q <= nlf_pkg::LINE_SIZE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      line_size_q <= cfg_data_i;
    end
  end

  nlf_front #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .func_i   (func_i),
    .rx_byte_i(rx_byte_i),
    .cmd_o    (front_cmd)
  );

  nlf_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_cmd_i  (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_valid_o(q_head_valid),
    .head_cmd_o  (head_cmd)
  );

  nlf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_size_i   (line_size_q),
    .head_valid_i  (q_head_valid),
    .head_cmd_i    (head_cmd),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .line_write_o  (line_write_o),
    .line_pos_out_o(line_pos_out_o),
    .line_char_o   (line_char_o),
    .line_length_o (line_length_o),
    .drop_total_o  (drop_total_o),
    .fifo_level_o  (fifo_level_o)
  );

endmodule

@@ verif/nlf_line_checker.sv @@
// ----------------------------------------------------------------------------
// nlf_line_checker
// Watches the word, result and line_size channels of the NMEA line framer,
// predicts each result from its own copy of the FIFO and framer state, and
// compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module nlf_line_checker #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        func_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [3:0]        action_i,
  input  logic              line_write_i,
  input  logic [7:0]        line_pos_out_i,
  input  logic [7:0]        line_char_i,
  input  logic [7:0]        line_length_i,
  input  logic [31:0]       drop_total_i,
  input  logic [7:0]        fifo_level_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [7:0]        cfg_data_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       outstanding_o
);

  typedef struct packed {
    nlf_pkg::action_e action;
    logic             line_write;
    logic [7:0]       line_pos;
    logic [7:0]       line_char;
    logic [7:0]       line_length;
    logic [31:0]      drop_total;
    logic [7:0]       fifo_level;
  } line_result_t;

  line_result_t pending_results[$];
  line_result_t want;

  logic [7:0]   byte_ring [FIFO_DEPTH];
  int unsigned  head;
  int unsigned  tail;
  logic [31:0]  drop_count;
  logic [7:0]   sentence_pos;
  logic [7:0]   line_size;
  int unsigned  mismatches = 0;

  // One step of the FIFO and the framer; updates the shadow state.
  function automatic line_result_t frame_step(nlf_pkg::func_e f, logic [7:0] rx);
    line_result_t r;
    logic [7:0]   b;
    logic [7:0]   limit;
    r = '0;
    r.action = nlf_pkg::ACT_IGNORED;
    case (f)
      nlf_pkg::FUNC_PUSH: begin
        if ((head + 1) % FIFO_DEPTH != tail) begin
          byte_ring[head] = rx;
          head = (head + 1) % FIFO_DEPTH;
          r.action = nlf_pkg::ACT_QUEUED;
        end else begin
          drop_count = drop_count + 32'd1;
          r.action = nlf_pkg::ACT_FULL;
        end
      end
      nlf_pkg::FUNC_PULL: begin
        if (head == tail) begin
          r.action = nlf_pkg::ACT_EMPTY;
        end else begin
          b = byte_ring[tail];
          tail = (tail + 1) % FIFO_DEPTH;
          limit = ((line_size < nlf_pkg::LINE_SIZE_MIN) ? nlf_pkg::LINE_SIZE_MIN
                                                        : line_size) - 8'd1;
          if (b == nlf_pkg::CHAR_DOLLAR) begin
            r.line_write = 1'b1;
            r.line_char = b;
            sentence_pos = 8'd1;
            r.action = nlf_pkg::ACT_START;
          end else if (sentence_pos == 8'd0) begin
            r.action = nlf_pkg::ACT_IGNORED;
          end else if (sentence_pos >= limit) begin
            sentence_pos = 8'd0;
            drop_count = drop_count + 32'd1;
            r.action = nlf_pkg::ACT_TOO_LONG;
          end else begin
            r.line_write = 1'b1;
            r.line_pos = sentence_pos;
            r.line_char = b;
            sentence_pos = sentence_pos + 8'd1;
            if (b == nlf_pkg::CHAR_LF || b == nlf_pkg::CHAR_CR) begin
              r.line_length = sentence_pos;
              sentence_pos = 8'd0;
              r.action = nlf_pkg::ACT_DONE;
            end else begin
              r.action = nlf_pkg::ACT_STORED;
            end
          end
        end
      end
      nlf_pkg::FUNC_CLEAR: begin
        head = 0;
        tail = 0;
        drop_count = '0;
        r.action = nlf_pkg::ACT_CLEARED;
      end
      default: ;
    endcase
    r.drop_total = drop_count;
    r.fifo_level = 8'((head + FIFO_DEPTH - tail) % FIFO_DEPTH);
    return r;
  endfunction

  task automatic check_field(input string label, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, label, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head = 0;
      tail = 0;
      drop_count = '0;
      sentence_pos = '0;
      line_size = nlf_pkg::LINE_SIZE_RST;
      pending_results.delete();
      outstanding_o <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      // Results first, so a word accepted on this edge cannot mask an
      // unexpected result.
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result expected none, got action %0d", $time, action_i);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("action", 32'(want.action), 32'(action_i));
          check_field("line_write", 32'(want.line_write), 32'(line_write_i));
          check_field("line_pos_out", 32'(want.line_pos), 32'(line_pos_out_i));
          check_field("line_char", 32'(want.line_char), 32'(line_char_i));
          check_field("line_length", 32'(want.line_length), 32'(line_length_i));
          check_field("drop_total", want.drop_total, drop_total_i);
          check_field("fifo_level", 32'(want.fifo_level), 32'(fifo_level_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_results.push_back(frame_step(nlf_pkg::func_e'(func_i), rx_byte_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        line_size = cfg_data_i;
      end
      outstanding_o <= pending_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the NMEA line framer with receive FIFO. Drives
// short directed sequences, then random phases at several line sizes with
// well-formed sentences, noise words, clears and a FIFO overflow, while
// both sides of the word channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  logic           clk;
  logic           rst_n;

  logic           in_valid;
  logic           in_stall;
  nlf_pkg::func_e func;
  logic [7:0]     rx_byte;

  logic        out_valid;
  logic        out_stall;
  logic [3:0]  action;
  logic        line_write;
  logic [7:0]  line_pos_out;
  logic [7:0]  line_char;
  logic [7:0]  line_length;
  logic [31:0] drop_total;
  logic [7:0]  fifo_level;

  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  int unsigned mismatch_count;
  int unsigned outstanding;

  // When calm is set, neither side idles nor stalls, so the block runs at its
  // full rate of one word per clock.
  bit          calm;
  // Number of words accepted so far, and a rough estimate of the FIFO fill
  // level used only to decide how many pulls to issue.
  int unsigned words_sent;
  int          backlog;

  nmea_line_framer_with_fifo_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .action_o       (action),
    .line_write_o   (line_write),
    .line_pos_out_o (line_pos_out),
    .line_char_o    (line_char),
    .line_length_o  (line_length),
    .drop_total_o   (drop_total),
    .fifo_level_o   (fifo_level),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  nlf_line_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .func_i           (func),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .action_i         (action),
    .line_write_i     (line_write),
    .line_pos_out_i   (line_pos_out),
    .line_char_i      (line_char),
    .line_length_i    (line_length),
    .drop_total_i     (drop_total),
    .fifo_level_i     (fifo_level),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Safety net: even the slowest legal run finishes well inside this bound.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver side. The stall line holds each chosen level for a random number
  // of cycles: mostly short stretches, now and then a long stall that backs
  // the queue up into the sender.
  initial begin
    int          hold;
    int unsigned r;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          hold = $urandom_range(0, 6);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          hold = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  // Idle cycles before the next word: usually none or a few, rarely many.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one word and returns on the edge that accepts it. Valid stays high
  // into the next word unless a gap is chosen, so it never drops and rises
  // within one time step.
  task automatic send_word(input nlf_pkg::func_e f, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
    case (f)
      nlf_pkg::FUNC_PUSH:  if (backlog < 255) backlog++;
      nlf_pkg::FUNC_PULL:  if (backlog > 0) backlog--;
      nlf_pkg::FUNC_CLEAR: backlog = 0;
      default: ;
    endcase
  endtask

  task automatic pull_byte();
    send_word(nlf_pkg::FUNC_PULL, 8'($urandom));
  endtask

  // Drops valid and waits until every result has come back, with a bound.
  task automatic go_idle();
    int n;
    in_valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < 5000 && outstanding != 0; n++) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_line_size(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Sentence body character: any byte, but the sentence delimiters are kept
  // rare so that most sentences run to their intended length.
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    c = 8'($urandom);
    if ((c == nlf_pkg::CHAR_DOLLAR || c == nlf_pkg::CHAR_CR || c == nlf_pkg::CHAR_LF)
        && $urandom_range(0, 7) != 0)
      c = 8'h41 + 8'(c % 26);
    return c;
  endfunction

  // Pushes '$', body_len body characters and usually a CR or LF, with pulls
  // mixed in, then usually drains the FIFO so the whole line gets framed.
  task automatic send_sentence(input int body_len);
    int          i;
    int unsigned r;
    logic [7:0]  c;
    for (i = 0; i < body_len + 2; i++) begin
      if (i == 0) begin
        c = nlf_pkg::CHAR_DOLLAR;
      end else if (i <= body_len) begin
        c = body_char();
      end else begin
        r = $urandom_range(0, 99);
        if (r >= 90) break;   // unterminated; the next '$' restarts the line
        c = (r < 45) ? nlf_pkg::CHAR_CR : nlf_pkg::CHAR_LF;
      end
      send_word(nlf_pkg::FUNC_PUSH, c);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        pull_byte();
      end else if (r < 60) begin
        pull_byte();
        pull_byte();
      end
    end
    if ($urandom_range(0, 9) < 7) begin
      while (backlog > 0) pull_byte();
    end
  endtask

  // Body length: mostly short, sometimes right around the line size limit so
  // that both the longest completed line and the too-long case occur.
  function automatic int pick_body_len(input logic [7:0] size);
    int          limit;
    int unsigned r;
    limit = ((size < nlf_pkg::LINE_SIZE_MIN) ? nlf_pkg::LINE_SIZE_MIN : size) - 1;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 12);
    if (r < 90) begin
      return (limit < 3) ? $urandom_range(0, limit) : $urandom_range(limit - 3, limit);
    end
    return $urandom_range(0, 80);
  endfunction

  localparam int NUM_PHASES = 9;

  initial begin
    logic [7:0]  sizes [NUM_PHASES];
    int          p;
    int          i;
    int unsigned r;
    int unsigned target;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    func      <= nlf_pkg::FUNC_NONE;
    rx_byte   <= 8'd0;
    cfg_valid <= 1'b0;
    cfg_data  <= 8'd0;
    calm = 1'b0;
    words_sent = 0;
    backlog = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset line size.
    // Pull from an empty FIFO, then an unknown function code.
    send_word(nlf_pkg::FUNC_PULL, 8'hFF);
    send_word(nlf_pkg::FUNC_NONE, 8'h00);
    // Extreme byte values arriving before any sentence start are ignored.
    send_word(nlf_pkg::FUNC_PUSH, 8'hFF);
    send_word(nlf_pkg::FUNC_PUSH, 8'h00);
    pull_byte();
    pull_byte();
    // A short CR-terminated sentence.
    send_word(nlf_pkg::FUNC_PUSH, nlf_pkg::CHAR_DOLLAR);
    send_word(nlf_pkg::FUNC_PUSH, 8'h47);
    send_word(nlf_pkg::FUNC_PUSH, nlf_pkg::CHAR_CR);
    repeat (3) pull_byte();
    // A '$' in the middle of a sentence restarts it; LF ends the line.
    send_word(nlf_pkg::FUNC_PUSH, nlf_pkg::CHAR_DOLLAR);
    send_word(nlf_pkg::FUNC_PUSH, 8'h41);
    send_word(nlf_pkg::FUNC_PUSH, nlf_pkg::CHAR_DOLLAR);
    send_word(nlf_pkg::FUNC_PUSH, 8'h42);
    send_word(nlf_pkg::FUNC_PUSH, nlf_pkg::CHAR_LF);
    repeat (5) pull_byte();
    // Clear with a byte still queued.
    send_word(nlf_pkg::FUNC_PUSH, 8'h5A);
    send_word(nlf_pkg::FUNC_CLEAR, 8'h00);
    pull_byte();

    // Random phases. Line sizes of 0 and 1 behave like 2, where every byte
    // after the start is too long; 255 gives the longest possible lines.
    sizes[0] = 8'd2;
    sizes[1] = 8'd0;
    sizes[2] = 8'd255;
    sizes[3] = 8'd1;
    sizes[4] = nlf_pkg::LINE_SIZE_RST;
    sizes[5] = 8'd3;
    sizes[6] = 8'($urandom_range(4, 40));
    sizes[7] = 8'($urandom_range(2, 255));
    sizes[8] = nlf_pkg::LINE_SIZE_RST;

    for (p = 0; p < NUM_PHASES; p++) begin
      // The line size changes only with nothing in flight.
      go_idle();
      write_line_size(sizes[p]);
      calm = (p % 3 == 2);

      if (sizes[p] == 8'd255) begin
        // Longest completed line pushed into an empty FIFO without pulls,
        // then two more bytes: the first fills all 255 entries and the
        // second is dropped and counted. Draining frames the whole line.
        send_word(nlf_pkg::FUNC_CLEAR, 8'h00);
        send_word(nlf_pkg::FUNC_PUSH, nlf_pkg::CHAR_DOLLAR);
        for (i = 0; i < 252; i++) begin
          send_word(nlf_pkg::FUNC_PUSH, 8'h41 + 8'($urandom_range(0, 25)));
        end
        send_word(nlf_pkg::FUNC_PUSH, nlf_pkg::CHAR_CR);
        send_word(nlf_pkg::FUNC_PUSH, 8'($urandom));
        send_word(nlf_pkg::FUNC_PUSH, 8'($urandom));
        while (backlog > 0) pull_byte();
      end

      target = words_sent + 28;
      while (words_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          send_sentence(pick_body_len(sizes[p]));
        end else if (r < 92) begin
          send_word(nlf_pkg::func_e'($urandom_range(0, 3)), 8'($urandom));
        end else if (r < 96) begin
          send_word(nlf_pkg::FUNC_CLEAR, 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 6)) pull_byte();
        end
      end
    end

    // Let every result drain, then give the verdict.
    calm = 1'b1;
    go_idle();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/nlf_pkg.sv
hdl/nlf_front.sv
hdl/nlf_cmd_queue.sv
hdl/nlf_back.sv
hdl/nmea_line_framer_with_fifo_core.sv
verif/nlf_line_checker.sv
verif/tb_top.sv
